/* design/rtt_pkg.sv */
// Shared types, codes and constants of the retransmit tracking table.
package rtt_pkg;

    localparam int RTT_ENTRIES = 16;
    localparam logic [15:0] SEQ_TOP = 16'hffff;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_CONFIRM = 2'd2,
        CMD_DIRECT  = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        KIND_TRANSMIT   = 3'd0,
        KIND_ACCEPTED   = 3'd1,
        KIND_REJECTED   = 3'd2,
        KIND_COMPLETION = 3'd3,
        KIND_MISS       = 3'd4
    } kind_t;

    // which result the datapath builds on a push
    typedef enum logic [2:0] {
        RES_ENQ_TX,
        RES_ACCEPT,
        RES_REJECT,
        RES_TICK,
        RES_CONF_DONE,
        RES_MISS,
        RES_DIRECT
    } res_sel_t;

    // slot RAM read address source
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_CUR
    } rd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENQ_WR,
        ST_ENQ_ACC,
        ST_WALK_TICK,
        ST_WALK_CONF,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [9:0]  handle;
        logic        notify;
        logic [7:0]  wait_limit;
    } slot_info_t;

    typedef struct packed {
        logic [7:0] sends_left;
        logic [7:0] wait_count;
    } slot_dyn_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq;
        logic [9:0]  handle;
        logic [7:0]  status;
        logic        timed_out;
        logic        notify;
    } result_t;

    typedef struct packed {
        logic     load_in;
        rd_sel_t  rd_sel;
        logic     walk_start;
        logic     walk_step;
        logic     walk_remove;
        logic     tick_write;
        logic     enq_commit;
        logic     draw_seq;
        logic     push;
        res_sel_t res_sel;
        logic     flush;
    } rtt_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      full;
        logic      empty;
        logic      push_ok;
        logic      flush_ok;
        logic      pend_valid;
        logic      walk_last;
        logic      expire;
        logic      timeout;
        logic      match;
    } rtt_stat_t;

endpackage

/* design/retransmit_tracking_table_core.sv */
// Top level of the retransmit tracking table: controller plus datapath.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | s_tuser: cmd; s_tdata: handle, retries, wait, ...
//  m_      | out | m_tvalid / m_tready | m_tuser: kind; m_tdata: seq, handle, ...; m_tlast
//
// Tick and confirm walk the order list through the slot RAMs, with each next pointer read
// feeding the following read address.
// Results pass a one-word holding stage so the final word can carry m_tlast.
// A stalled m_tready holds the walk on an entry that must push a result; words are never dropped.
// aresetn (synchronous) empties the table at once; no clearing pass is needed.
module retransmit_tracking_table_core #(
    parameter int ENTRIES = rtt_pkg::RTT_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] packet_handle, [17:10] retries, [25:18] wait_ticks, [26] notify_wanted,
    // [42:27] ack_seq, [50:43] ack_result
    input  logic [rtt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [rtt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] seq, [25:16] handle_out, [33:26] status, [34] timed_out, [35] notify
    output logic [rtt_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] kind
    output logic [rtt_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import rtt_pkg::*;

    rtt_cmd_t  ctl_cmd;
    rtt_stat_t dp_stat;

    rtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    rtt_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (ctl_cmd),
        .stat     (dp_stat)
    );

endmodule

/* design/rtt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/rtt_ctrl.sv */
// Controller state machine: sequences enqueue, list walks and result flushes.
module rtt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rtt_pkg::rtt_stat_t stat,
    output rtt_pkg::rtt_cmd_t  cmd
);
    import rtt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // no word is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_CUR;
        cmd.res_sel = RES_REJECT;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            // result buffer is empty here, so pushes never wait
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_ENQUEUE: begin
                        if (stat.full) begin
                            cmd.push    = 1'b1;
                            cmd.res_sel = RES_REJECT;
                            state_next  = ST_FLUSH;
                        end else begin
                            state_next = ST_ENQ_WR;
                        end
                    end
                    CMD_TICK: begin
                        if (stat.empty) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.walk_start = 1'b1;
                            cmd.rd_sel     = RD_HEAD;
                            state_next     = ST_WALK_TICK;
                        end
                    end
                    CMD_CONFIRM: begin
                        if (stat.empty) begin
                            cmd.push    = 1'b1;
                            cmd.res_sel = RES_MISS;
                            state_next  = ST_FLUSH;
                        end else begin
                            cmd.walk_start = 1'b1;
                            cmd.rd_sel     = RD_HEAD;
                            state_next     = ST_WALK_CONF;
                        end
                    end
                    CMD_DIRECT: begin
                        cmd.push     = 1'b1;
                        cmd.draw_seq = 1'b1;
                        cmd.res_sel  = RES_DIRECT;
                        state_next   = ST_FLUSH;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ENQ_WR: begin
                if (stat.push_ok) begin
                    cmd.enq_commit = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.res_sel    = RES_ENQ_TX;
                    state_next     = ST_ENQ_ACC;
                end
            end
            ST_ENQ_ACC: begin
                if (stat.push_ok) begin
                    cmd.push    = 1'b1;
                    cmd.res_sel = RES_ACCEPT;
                    state_next  = ST_FLUSH;
                end
            end
            ST_WALK_TICK: begin
                cmd.res_sel = RES_TICK;
                // hold on the current entry while a result cannot be taken
                if (!stat.expire || stat.push_ok) begin
                    cmd.walk_step   = 1'b1;
                    cmd.tick_write  = 1'b1;
                    cmd.walk_remove = stat.timeout;
                    cmd.push        = stat.expire;
                    cmd.rd_sel      = RD_NEXT;
                    if (stat.walk_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_WALK_CONF: begin
                if (stat.match) begin
                    if (stat.push_ok) begin
                        cmd.walk_step   = 1'b1;
                        cmd.walk_remove = 1'b1;
                        cmd.push        = 1'b1;
                        cmd.res_sel     = RES_CONF_DONE;
                        state_next      = ST_FLUSH;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                    if (stat.walk_last) begin
                        cmd.push    = 1'b1;
                        cmd.res_sel = RES_MISS;
                        state_next  = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.flush_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/rtt_datapath.sv */
// Datapath: slot RAMs, order list pointers, free slot stack and result registers.
module rtt_datapath #(
    parameter int ENTRIES = rtt_pkg::RTT_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [rtt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [rtt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rtt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rtt_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast,
    input  rtt_pkg::rtt_cmd_t              cmd,
    output rtt_pkg::rtt_stat_t             stat
);
    import rtt_pkg::*;

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(ENTRIES);

    // latched input word
    cmd_code_t   in_cmd_reg;
    logic [9:0]  in_handle_reg;
    logic [7:0]  in_retries_reg;
    logic [7:0]  in_wait_reg;
    logic        in_notify_reg;
    logic [15:0] in_ack_seq_reg;
    logic [7:0]  in_ack_result_reg;

    // list and allocation state
    logic [IDXW-1:0] head_reg, tail_reg;
    logic [CNTW-1:0] live_reg;
    logic [15:0]     seq_reg;
    logic [CNTW-1:0] fill_reg, sp_reg;

    // walk state
    logic [IDXW-1:0] cur_reg, prev_reg;
    logic            has_prev_reg;
    logic [CNTW-1:0] remaining_reg;

    // result staging: pending word, then output register
    result_t pend_reg;
    logic    pend_valid_reg;
    result_t out_reg;
    logic    out_valid_reg, out_last_reg;

    slot_info_t      info_rd;
    slot_dyn_t       dyn_rd;
    logic [IDXW-1:0] next_rd, stack_rd;
    logic [IDXW-1:0] rd_addr;

    logic [15:0]     seq_new;
    logic [IDXW-1:0] alloc_slot;
    logic [CNTW-1:0] sp_dec;
    logic [7:0]      wc_inc, sl_dec;
    logic            expire, out_free;
    result_t         res_new;

    logic            info_we, dyn_we, next_we, stack_we;
    slot_info_t      info_wdata;
    slot_dyn_t       dyn_wdata;
    logic [IDXW-1:0] dyn_waddr, next_waddr, next_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg        <= cmd_code_t'(s_tuser);
            in_handle_reg     <= s_tdata[9:0];
            in_retries_reg    <= s_tdata[17:10];
            in_wait_reg       <= s_tdata[25:18];
            in_notify_reg     <= s_tdata[26];
            in_ack_seq_reg    <= s_tdata[42:27];
            in_ack_result_reg <= s_tdata[50:43];
        end
    end

    assign seq_new    = (seq_reg == SEQ_TOP) ? 16'd1 : seq_reg + 16'd1;
    assign sp_dec     = sp_reg - CNTW'(1);
    assign alloc_slot = (fill_reg < FULL_CNT) ? fill_reg[IDXW-1:0] : stack_rd;
    assign wc_inc     = dyn_rd.wait_count + 8'd1;
    assign sl_dec     = dyn_rd.sends_left - 8'd1;
    assign expire     = (wc_inc > info_rd.wait_limit);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        case (cmd.rd_sel)
            RD_HEAD: rd_addr = head_reg;
            RD_NEXT: rd_addr = next_rd;
            RD_CUR:  rd_addr = cur_reg;
            default: rd_addr = cur_reg;
        endcase
    end

    // RAM write ports
    always_comb begin
        info_we    = cmd.enq_commit;
        info_wdata = '{seq: seq_new, handle: in_handle_reg, notify: in_notify_reg,
                       wait_limit: in_wait_reg};
        dyn_we     = cmd.enq_commit || cmd.tick_write;
        if (cmd.enq_commit) begin
            dyn_waddr = alloc_slot;
            dyn_wdata = '{sends_left: in_retries_reg, wait_count: 8'd0};
        end else begin
            dyn_waddr = cur_reg;
            if (expire) begin
                dyn_wdata = '{sends_left: sl_dec, wait_count: 8'd0};
            end else begin
                dyn_wdata = '{sends_left: dyn_rd.sends_left, wait_count: wc_inc};
            end
        end
        if (cmd.enq_commit) begin
            next_we    = (live_reg != '0);
            next_waddr = tail_reg;
            next_wdata = alloc_slot;
        end else begin
            next_we    = cmd.walk_remove && has_prev_reg;
            next_waddr = prev_reg;
            next_wdata = next_rd;
        end
        stack_we = cmd.walk_remove;
    end

    rtt_ram #(.WIDTH($bits(slot_info_t)), .DEPTH(ENTRIES)) u_info_ram (
        .aclk  (aclk),
        .we    (info_we),
        .waddr (alloc_slot),
        .wdata (info_wdata),
        .raddr (rd_addr),
        .rdata (info_rd)
    );

    rtt_ram #(.WIDTH($bits(slot_dyn_t)), .DEPTH(ENTRIES)) u_dyn_ram (
        .aclk  (aclk),
        .we    (dyn_we),
        .waddr (dyn_waddr),
        .wdata (dyn_wdata),
        .raddr (rd_addr),
        .rdata (dyn_rd)
    );

    rtt_ram #(.WIDTH(IDXW), .DEPTH(ENTRIES)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    // freed slots; never-used slots come from the fill count instead
    rtt_ram #(.WIDTH(IDXW), .DEPTH(ENTRIES)) u_free_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (sp_reg[IDXW-1:0]),
        .wdata (cur_reg),
        .raddr (sp_dec[IDXW-1:0]),
        .rdata (stack_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            live_reg      <= '0;
            seq_reg       <= SEQ_TOP;
            fill_reg      <= '0;
            sp_reg        <= '0;
            has_prev_reg  <= 1'b0;
            remaining_reg <= '0;
        end else begin
            if (cmd.enq_commit || cmd.draw_seq) begin
                seq_reg <= seq_new;
            end
            if (cmd.enq_commit) begin
                if (live_reg == '0) begin
                    head_reg <= alloc_slot;
                end
                tail_reg <= alloc_slot;
                live_reg <= live_reg + CNTW'(1);
                if (fill_reg < FULL_CNT) begin
                    fill_reg <= fill_reg + CNTW'(1);
                end else begin
                    sp_reg <= sp_dec;
                end
            end
            if (cmd.walk_start) begin
                has_prev_reg  <= 1'b0;
                remaining_reg <= live_reg;
            end
            if (cmd.walk_step) begin
                remaining_reg <= remaining_reg - CNTW'(1);
                if (!cmd.walk_remove) begin
                    has_prev_reg <= 1'b1;
                end
            end
            if (cmd.walk_remove) begin
                sp_reg   <= sp_reg + CNTW'(1);
                live_reg <= live_reg - CNTW'(1);
                if (live_reg == CNTW'(1)) begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end else begin
                    if (!has_prev_reg) begin
                        head_reg <= next_rd;
                    end
                    if (cur_reg == tail_reg) begin
                        tail_reg <= has_prev_reg ? prev_reg : '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            cur_reg <= head_reg;
        end
        if (cmd.walk_step) begin
            cur_reg <= next_rd;
            if (!cmd.walk_remove) begin
                prev_reg <= cur_reg;
            end
        end
    end

    always_comb begin
        res_new = '{kind: KIND_REJECTED, seq: 16'd0, handle: 10'd0, status: 8'd0,
                    timed_out: 1'b0, notify: 1'b0};
        case (cmd.res_sel)
            RES_ENQ_TX, RES_DIRECT: begin
                res_new.kind   = KIND_TRANSMIT;
                res_new.seq    = seq_new;
                res_new.handle = in_handle_reg;
            end
            RES_ACCEPT: begin
                res_new.kind = KIND_ACCEPTED;
                res_new.seq  = seq_reg;
            end
            RES_REJECT: begin
                res_new.kind = KIND_REJECTED;
            end
            RES_TICK: begin
                res_new.seq    = info_rd.seq;
                res_new.handle = info_rd.handle;
                if (sl_dec == 8'd0) begin
                    res_new.kind      = KIND_COMPLETION;
                    res_new.timed_out = 1'b1;
                    res_new.notify    = info_rd.notify;
                end else begin
                    res_new.kind = KIND_TRANSMIT;
                end
            end
            RES_CONF_DONE: begin
                res_new.kind   = KIND_COMPLETION;
                res_new.seq    = info_rd.seq;
                res_new.handle = info_rd.handle;
                res_new.status = in_ack_result_reg;
                res_new.notify = info_rd.notify;
            end
            RES_MISS: begin
                res_new.kind = KIND_MISS;
            end
            default: begin
                res_new.kind = KIND_REJECTED;
            end
        endcase
    end

    // a result waits in pend until the next one shows it is not the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.push) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.push && pend_valid_reg) || cmd.flush) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            pend_reg <= res_new;
        end
        if ((cmd.push && pend_valid_reg) || cmd.flush) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_reg.notify, out_reg.timed_out, out_reg.status,
                       out_reg.handle, out_reg.seq};

    always_comb begin
        stat            = '0;
        stat.cmd        = in_cmd_reg;
        stat.full       = (live_reg == FULL_CNT);
        stat.empty      = (live_reg == '0);
        stat.push_ok    = !pend_valid_reg || out_free;
        stat.flush_ok   = out_free;
        stat.pend_valid = pend_valid_reg;
        stat.walk_last  = (remaining_reg == CNTW'(1));
        stat.expire     = expire;
        stat.timeout    = expire && (sl_dec == 8'd0);
        stat.match      = (info_rd.seq == in_ack_seq_reg);
    end

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= FULL_CNT)
        else $error("live count above table size");

    a_free_acct: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg == fill_reg - sp_reg)
        else $error("free slot accounting broken");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("list pointers not cleared on empty table");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        remaining_reg <= live_reg)
        else $error("walk count exceeds live entries");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> out_valid_reg && out_last_reg)
        else $error("flushed word not marked last");

endmodule

/* dv/retransmit_tracking_table_core_test.sv */
// Self-checking stream testbench for the retransmit tracking table core.
module retransmit_tracking_table_core_test;
    import rtt_pkg::*;

    localparam int ENTRIES     = RTT_ENTRIES;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_CMDS = 130;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq;
        logic [9:0]  handle;
        logic [7:0]  status;
        logic        timed_out;
        logic        notify;
        logic        last;
    } rtt_word_t;

    typedef struct packed {
        cmd_code_t   cmd;
        logic [9:0]  handle;
        logic [7:0]  retries;
        logic [7:0]  wait_ticks;
        logic        ntf;
        logic [15:0] ack_seq;
        logic [7:0]  ack_res;
        logic        typed;     // expectation written in the row, not predicted
        logic        has_word;
        rtt_word_t   want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // table mirror
    logic        ent_valid  [ENTRIES];
    logic [15:0] ent_seq    [ENTRIES];
    logic [7:0]  ent_sends  [ENTRIES];
    logic [7:0]  ent_count  [ENTRIES];
    logic [7:0]  ent_limit  [ENTRIES];
    logic [9:0]  ent_handle [ENTRIES];
    logic        ent_notify [ENTRIES];
    logic [3:0]  ent_next   [ENTRIES];
    logic [3:0]  list_head;
    logic [3:0]  list_tail;
    logic [4:0]  live_slots;
    logic [15:0] last_seq;

    rtt_word_t   awaited_words[$];
    stim_row_t   directed_rows[$];

    int          mismatch_count = 0;
    int          checked_words = 0;
    int          accepted_cmds = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    retransmit_tracking_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [15:0] draw_next_seq();
        last_seq = (last_seq == SEQ_TOP) ? 16'd1 : last_seq + 16'd1;
        return last_seq;
    endfunction

    function automatic void add_word(kind_t k, logic [15:0] s, logic [9:0] h,
                                     logic [7:0] st, logic to, logic nt);
        rtt_word_t w;
        w.kind      = k;
        w.seq       = s;
        w.handle    = h;
        w.status    = st;
        w.timed_out = to;
        w.notify    = nt;
        w.last      = 1'b0;
        awaited_words.push_back(w);
    endfunction

    function automatic void drop_slot(bit has_prev, logic [3:0] prev, logic [3:0] cur);
        if (!has_prev) begin
            list_head = ent_next[cur];
        end else begin
            ent_next[prev] = ent_next[cur];
        end
        if (cur == list_tail) list_tail = has_prev ? prev : 4'd0;
        ent_valid[cur] = 1'b0;
        if (live_slots > 0) live_slots--;
        if (live_slots == 0) begin
            list_head = '0;
            list_tail = '0;
        end
    endfunction

    // advance the mirror by one command and queue the words it must produce
    function automatic void apply_to_table(stim_row_t r);
        int          base;
        int          s;
        int          remaining;
        logic [3:0]  cur;
        logic [3:0]  prev;
        logic [3:0]  nxt;
        bit          has_prev;
        bit          found;
        bit          removed;
        logic [15:0] q;
        rtt_word_t   tail_word;
        base = awaited_words.size();
        case (r.cmd)
            CMD_ENQUEUE: begin
                s = 0;
                while (s < ENTRIES && ent_valid[s]) s++;
                if (live_slots >= ENTRIES || s >= ENTRIES) begin
                    add_word(KIND_REJECTED, '0, '0, '0, 1'b0, 1'b0);
                end else begin
                    q = draw_next_seq();
                    ent_valid[s]  = 1'b1;
                    ent_seq[s]    = q;
                    ent_sends[s]  = r.retries;
                    ent_count[s]  = '0;
                    ent_limit[s]  = r.wait_ticks;
                    ent_handle[s] = r.handle;
                    ent_notify[s] = r.ntf;
                    ent_next[s]   = '0;
                    if (live_slots == 0) begin
                        list_head = 4'(s);
                    end else begin
                        ent_next[list_tail] = 4'(s);
                    end
                    list_tail = 4'(s);
                    live_slots++;
                    add_word(KIND_TRANSMIT, q, r.handle, '0, 1'b0, 1'b0);
                    add_word(KIND_ACCEPTED, q, '0, '0, 1'b0, 1'b0);
                end
            end
            CMD_TICK: begin
                remaining = live_slots;
                cur = list_head;
                prev = '0;
                has_prev = 1'b0;
                while (remaining > 0) begin
                    nxt = ent_next[cur];
                    removed = 1'b0;
                    remaining--;
                    ent_count[cur] = ent_count[cur] + 8'd1;
                    if (ent_count[cur] > ent_limit[cur]) begin
                        ent_count[cur] = '0;
                        ent_sends[cur] = ent_sends[cur] - 8'd1;
                        if (ent_sends[cur] == 0) begin
                            add_word(KIND_COMPLETION, ent_seq[cur], ent_handle[cur], '0,
                                     1'b1, ent_notify[cur]);
                            drop_slot(has_prev, prev, cur);
                            removed = 1'b1;
                        end else begin
                            add_word(KIND_TRANSMIT, ent_seq[cur], ent_handle[cur], '0,
                                     1'b0, 1'b0);
                        end
                    end
                    if (!removed) begin
                        prev = cur;
                        has_prev = 1'b1;
                    end
                    cur = nxt;
                end
            end
            CMD_CONFIRM: begin
                remaining = live_slots;
                cur = list_head;
                prev = '0;
                has_prev = 1'b0;
                found = 1'b0;
                while (remaining > 0 && !found) begin
                    remaining--;
                    if (ent_seq[cur] == r.ack_seq) begin
                        add_word(KIND_COMPLETION, ent_seq[cur], ent_handle[cur], r.ack_res,
                                 1'b0, ent_notify[cur]);
                        drop_slot(has_prev, prev, cur);
                        found = 1'b1;
                    end else begin
                        prev = cur;
                        has_prev = 1'b1;
                        cur = ent_next[cur];
                    end
                end
                if (!found) add_word(KIND_MISS, '0, '0, '0, 1'b0, 1'b0);
            end
            default: begin
                q = draw_next_seq();
                add_word(KIND_TRANSMIT, q, r.handle, '0, 1'b0, 1'b0);
            end
        endcase
        if (awaited_words.size() > base) begin
            tail_word = awaited_words.pop_back();
            tail_word.last = 1'b1;
            awaited_words.push_back(tail_word);
        end
    endfunction

    function automatic stim_row_t cmd_row(cmd_code_t c, logic [9:0] h, logic [7:0] rt,
                                          logic [7:0] wt, logic nt, logic [15:0] aq,
                                          logic [7:0] ar);
        stim_row_t r;
        r = '0;
        r.cmd = c;
        r.handle = h;
        r.retries = rt;
        r.wait_ticks = wt;
        r.ntf = nt;
        r.ack_seq = aq;
        r.ack_res = ar;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t   r;
        logic [15:0] live_seqs[$];
        int          pick;
        r = '0;
        r.handle     = 10'($urandom);
        r.retries    = 8'($urandom);
        r.wait_ticks = 8'($urandom);
        r.ntf        = 1'($urandom);
        r.ack_seq    = 16'($urandom);
        r.ack_res    = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) r.cmd = CMD_ENQUEUE;
        else if (pick < 65) r.cmd = CMD_TICK;
        else if (pick < 90) r.cmd = CMD_CONFIRM;
        else r.cmd = CMD_DIRECT;
        // short budgets and waits so entries actually age out
        if ($urandom_range(0, 9) < 7) r.retries = 8'($urandom_range(1, 4));
        pick = $urandom_range(0, 9);
        if (pick < 7) r.wait_ticks = 8'($urandom_range(0, 3));
        else if (pick == 7) r.wait_ticks = 8'hff;
        if (r.cmd == CMD_CONFIRM) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (ent_valid[i]) live_seqs.push_back(ent_seq[i]);
            end
            pick = $urandom_range(0, 9);
            if (live_seqs.size() > 0 && pick < 8) begin
                r.ack_seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
            end else if (pick == 9) begin
                r.ack_seq = '0;
            end
        end
        return r;
    endfunction

    task automatic offer_command(input stim_row_t r);
        int base;
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {5'd0, r.ack_res, r.ack_seq, r.ntf, r.wait_ticks, r.retries, r.handle};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accepted_cmds++;
        base = awaited_words.size();
        apply_to_table(r);
        if (r.typed) begin
            while (awaited_words.size() > base) void'(awaited_words.pop_back());
            if (r.has_word) awaited_words.push_back(r.want);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH at word %0d, %s: got %0h want %0h",
                     checked_words, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : watch_results
        rtt_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_words.size() == 0) begin
                flag_mismatch("unexpected word, kind", 16'(m_tuser), '0);
            end else begin
                want = awaited_words.pop_front();
                if (m_tuser[2:0] !== want.kind) flag_mismatch("kind", 16'(m_tuser), 16'(want.kind));
                if (m_tdata[15:0] !== want.seq) flag_mismatch("seq", m_tdata[15:0], want.seq);
                if (m_tdata[25:16] !== want.handle)
                    flag_mismatch("handle", 16'(m_tdata[25:16]), 16'(want.handle));
                if (m_tdata[33:26] !== want.status)
                    flag_mismatch("status", 16'(m_tdata[33:26]), 16'(want.status));
                if (m_tdata[34] !== want.timed_out)
                    flag_mismatch("timed_out", 16'(m_tdata[34]), 16'(want.timed_out));
                if (m_tdata[35] !== want.notify)
                    flag_mismatch("notify", 16'(m_tdata[35]), 16'(want.notify));
                if (m_tlast !== want.last) flag_mismatch("tlast", 16'(m_tlast), 16'(want.last));
            end
            checked_words++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("retransmit_tracking_table_core verification failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold when asked
    initial begin
        int hold_cycles;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin
        stim_row_t   r;
        logic [15:0] drain_seqs[$];
        int          directed_cmds;
        int          n;
        for (int i = 0; i < ENTRIES; i++) begin
            ent_valid[i] = 1'b0;
            ent_seq[i] = '0;
            ent_sends[i] = '0;
            ent_count[i] = '0;
            ent_limit[i] = '0;
            ent_handle[i] = '0;
            ent_notify[i] = 1'b0;
            ent_next[i] = '0;
        end
        list_head = '0;
        list_tail = '0;
        live_slots = '0;
        last_seq = SEQ_TOP;

        // directed rows
        r = cmd_row(CMD_TICK, '0, '0, '0, 1'b0, '0, '0);        // empty table: ignored
        r.typed = 1'b1;
        directed_rows.push_back(r);
        r = cmd_row(CMD_CONFIRM, '0, '0, '0, 1'b0, 16'd0, 8'd0); // seq 0 never matches
        r.typed = 1'b1;
        r.has_word = 1'b1;
        r.want = '{KIND_MISS, 16'd0, 10'd0, 8'd0, 1'b0, 1'b0, 1'b1};
        directed_rows.push_back(r);
        r = cmd_row(CMD_DIRECT, 10'h3ff, 8'hff, 8'hff, 1'b1, 16'hffff, 8'hff);
        r.typed = 1'b1;
        r.has_word = 1'b1;
        r.want = '{KIND_TRANSMIT, 16'd1, 10'h3ff, 8'd0, 1'b0, 1'b0, 1'b1};
        directed_rows.push_back(r);
        directed_rows.push_back(cmd_row(CMD_ENQUEUE, 10'h000, 8'd1, 8'd0, 1'b1, '0, '0));
        directed_rows.push_back(cmd_row(CMD_TICK, '0, '0, '0, 1'b0, '0, '0));
        directed_rows.push_back(cmd_row(CMD_ENQUEUE, 10'h3ff, 8'd0, 8'hff, 1'b0, '0, '0));
        directed_rows.push_back(cmd_row(CMD_ENQUEUE, 10'h155, 8'd2, 8'd0, 1'b1, '0, '0));
        directed_rows.push_back(cmd_row(CMD_TICK, '0, '0, '0, 1'b0, '0, '0));
        directed_rows.push_back(cmd_row(CMD_CONFIRM, '0, '0, '0, 1'b0, 16'd3, 8'hff));
        for (int i = 0; i < 15; i++) begin
            directed_rows.push_back(cmd_row(CMD_ENQUEUE, 10'(i * 67),
                                            (i == 7) ? 8'hff : 8'(i % 3 + 1), 8'(i % 2),
                                            1'(i), i[0] ? 16'hffff : 16'h0, 8'(i * 17)));
        end
        r = cmd_row(CMD_ENQUEUE, 10'h3ff, 8'hff, 8'hff, 1'b1, '0, '0); // table full
        r.typed = 1'b1;
        r.has_word = 1'b1;
        r.want = '{KIND_REJECTED, 16'd0, 10'd0, 8'd0, 1'b0, 1'b0, 1'b1};
        directed_rows.push_back(r);
        directed_rows.push_back(cmd_row(CMD_TICK, '0, '0, '0, 1'b0, '0, '0));
        r = cmd_row(CMD_CONFIRM, '0, '0, '0, 1'b0, 16'hffff, 8'h5a);
        r.typed = 1'b1;
        r.has_word = 1'b1;
        r.want = '{KIND_MISS, 16'd0, 10'd0, 8'd0, 1'b0, 1'b0, 1'b1};
        directed_rows.push_back(r);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) offer_command(directed_rows[i]);
        directed_cmds = accepted_cmds;

        // random traffic, with a quiet stretch and one long receiver hold
        n = 0;
        while (accepted_cmds < directed_cmds + RANDOM_CMDS) begin
            calm = (n >= 30 && n < 70);
            if (n == 100) begin
                hold_req = 1'b1;
                repeat (24) begin
                    r = random_row();
                    r.cmd = CMD_ENQUEUE;
                    offer_command(r);
                end
            end
            offer_command(random_row());
            n++;
        end
        calm = 1'b0;

        // empty the table by confirming every live entry
        for (int i = 0; i < ENTRIES; i++) begin
            if (ent_valid[i]) drain_seqs.push_back(ent_seq[i]);
        end
        foreach (drain_seqs[i]) begin
            offer_command(cmd_row(CMD_CONFIRM, 10'($urandom), '0, '0, 1'b0, drain_seqs[i],
                                  8'($urandom)));
        end

        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Ran %0d commands, %0d result words compared.", accepted_cmds, checked_words);
        $display("Covered full-table rejects, timeouts, a long receiver stall and a full drain.");
        if (mismatch_count == 0) begin
            $display("retransmit_tracking_table_core verification clean");
        end else begin
            $display("retransmit_tracking_table_core verification failed");
        end
        $finish;
    end

endmodule

/* retransmit_tracking_table_core.f */
design/rtt_pkg.sv
design/rtt_ram.sv
design/rtt_ctrl.sv
design/rtt_datapath.sv
design/retransmit_tracking_table_core.sv
dv/retransmit_tracking_table_core_test.sv
